// File: rtl/tpld_pkg.sv
// Shared types, codes and the operation sequence for the three-point Lagrange
// derivative block. Used by tpld_ctrl, tpld_datapath and the top level.
`default_nettype none

package tpld_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Datapath operations
    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_DIV1 = 3'd3;  // first derivative quotient
    localparam logic [2:0] OP_DIV2 = 3'd4;  // second derivative quotient

    // Working register selects (operands and destinations)
    localparam logic [3:0] SEL_H0   = 4'd0;
    localparam logic [3:0] SEL_H1   = 4'd1;
    localparam logic [3:0] SEL_HS   = 4'd2;
    localparam logic [3:0] SEL_D    = 4'd3;
    localparam logic [3:0] SEL_H0SQ = 4'd4;
    localparam logic [3:0] SEL_H1SQ = 4'd5;
    localparam logic [3:0] SEL_DIF  = 4'd6;
    localparam logic [3:0] SEL_ACC  = 4'd7;
    localparam logic [3:0] SEL_TMP  = 4'd8;
    localparam logic [3:0] SEL_F0   = 4'd9;
    localparam logic [3:0] SEL_F1   = 4'd10;
    localparam logic [3:0] SEL_F2   = 4'd11;

    // Step numbering of the sequence
    localparam logic [4:0] STEP_AXIS_FIRST = 5'd5;
    localparam logic [4:0] STEP_LAST       = 5'd16;
    localparam logic [1:0] AXIS_LAST       = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] dst;
    } instr_t;

    typedef struct packed {
        logic   capture;  // latch the accepted item
        logic   shift;    // slide the window, no result
        logic   calc_h;   // form the spacings
        logic   clr_sat;  // clear the clip flag
        logic   start;    // start one operation
        instr_t instr;
        logic [1:0] axis; // 0 = x, 1 = y, 2 = z
        logic   commit;   // load result registers and slide the window
        logic   degen;    // result is the degenerate one
    } cmd_t;

    typedef struct packed {
        logic done;       // operation finished (one-cycle pulse)
        logic degen;      // a spacing is zero
    } status_t;

    // Operation sequence: steps 0..4 once per item, 5..16 once per axis
    function automatic instr_t prog(input logic [4:0] step);
        instr_t i;
        i = '{op: OP_ADD, a: SEL_ACC, b: SEL_TMP, dst: SEL_ACC};
        case (step)
            5'd0:  i = '{op: OP_MUL, a: SEL_H0,   b: SEL_H1,   dst: SEL_TMP};
            5'd1:  i = '{op: OP_MUL, a: SEL_TMP,  b: SEL_HS,   dst: SEL_D};
            5'd2:  i = '{op: OP_MUL, a: SEL_H0,   b: SEL_H0,   dst: SEL_H0SQ};
            5'd3:  i = '{op: OP_MUL, a: SEL_H1,   b: SEL_H1,   dst: SEL_H1SQ};
            5'd4:  i = '{op: OP_SUB, a: SEL_H1SQ, b: SEL_H0SQ, dst: SEL_DIF};
            5'd5:  i = '{op: OP_MUL, a: SEL_F2,   b: SEL_H0SQ, dst: SEL_ACC};
            5'd6:  i = '{op: OP_MUL, a: SEL_F1,   b: SEL_DIF,  dst: SEL_TMP};
            5'd7:  i = '{op: OP_ADD, a: SEL_ACC,  b: SEL_TMP,  dst: SEL_ACC};
            5'd8:  i = '{op: OP_MUL, a: SEL_F0,   b: SEL_H1SQ, dst: SEL_TMP};
            5'd9:  i = '{op: OP_SUB, a: SEL_ACC,  b: SEL_TMP,  dst: SEL_ACC};
            5'd10: i = '{op: OP_DIV1, a: SEL_ACC, b: SEL_D,    dst: SEL_ACC};
            5'd11: i = '{op: OP_MUL, a: SEL_F0,   b: SEL_H1,   dst: SEL_ACC};
            5'd12: i = '{op: OP_MUL, a: SEL_F2,   b: SEL_H0,   dst: SEL_TMP};
            5'd13: i = '{op: OP_ADD, a: SEL_ACC,  b: SEL_TMP,  dst: SEL_ACC};
            5'd14: i = '{op: OP_MUL, a: SEL_F1,   b: SEL_HS,   dst: SEL_TMP};
            5'd15: i = '{op: OP_SUB, a: SEL_ACC,  b: SEL_TMP,  dst: SEL_ACC};
            5'd16: i = '{op: OP_DIV2, a: SEL_ACC, b: SEL_D,    dst: SEL_ACC};
            default: i = '{op: OP_ADD, a: SEL_ACC, b: SEL_TMP, dst: SEL_ACC};
        endcase
        return i;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tpld_ctrl.sv
// Controller for the three-point Lagrange derivative: handshakes, window fill
// count and the walk through the operation sequence. Depends on tpld_pkg.
`default_nettype none

module tpld_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           sample_valid,
    output logic                sample_ready,
    output logic                result_valid,
    input  wire logic           result_ready,
    output tpld_pkg::cmd_t      cmd,
    input  wire tpld_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] fill_reg, fill_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] axis_reg, axis_next;
    logic       degen_reg, degen_next;
    logic       rvalid_reg, rvalid_next;
    logic       slot_free;

    assign slot_free    = !rvalid_reg || result_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = rvalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        step_next   = step_reg;
        axis_next   = axis_reg;
        degen_next  = degen_reg;
        rvalid_next = rvalid_reg && !result_ready;
        cmd         = '0;
        cmd.instr   = tpld_pkg::prog(step_reg);
        cmd.axis    = axis_reg;
        cmd.degen   = degen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (fill_reg < 2'd2)
                begin
                    cmd.shift  = 1'b1;
                    fill_next  = fill_reg + 2'd1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.calc_h = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.clr_sat = 1'b1;
                step_next   = '0;
                axis_next   = '0;
                degen_next  = status.degen;
                state_next  = status.degen ? ST_FINISH : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.done)
                begin
                    state_next = ST_ISSUE;
                    if (step_reg == tpld_pkg::STEP_LAST)
                    begin
                        step_next = tpld_pkg::STEP_AXIS_FIRST;
                        axis_next = axis_reg + 2'd1;
                        if (axis_reg == tpld_pkg::AXIS_LAST)
                            state_next = ST_FINISH;
                    end
                    else
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit  = 1'b1;
                    rvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            step_reg   <= '0;
            axis_reg   <= '0;
            degen_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            step_reg   <= step_next;
            axis_reg   <= axis_next;
            degen_reg  <= degen_next;
            rvalid_reg <= rvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpld_datapath.sv
// Datapath for the three-point Lagrange derivative: sample window, wide
// working registers, shift-add multiplier and restoring divider. Depends on
// tpld_pkg.
`default_nettype none

module tpld_datapath #(
    parameter int DATA_WIDTH = tpld_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = tpld_pkg::FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [DATA_WIDTH-1:0] s_val,
    input  wire logic [DATA_WIDTH-1:0] x_val,
    input  wire logic [DATA_WIDTH-1:0] y_val,
    input  wire logic [DATA_WIDTH-1:0] z_val,
    input  wire tpld_pkg::cmd_t        cmd,
    output tpld_pkg::status_t          status,
    output logic [DATA_WIDTH-1:0]      dx_ds,
    output logic [DATA_WIDTH-1:0]      dy_ds,
    output logic [DATA_WIDTH-1:0]      dz_ds,
    output logic [DATA_WIDTH-1:0]      d2x_ds2,
    output logic [DATA_WIDTH-1:0]      d2y_ds2,
    output logic [DATA_WIDTH-1:0]      d2z_ds2,
    output logic                       degenerate,
    output logic                       saturated
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = 3 * DATA_WIDTH + 2 * FRAC_BITS + 6;  // working width
    localparam int BW = 2 * DATA_WIDTH + 3;                  // multiplier operand
    localparam int CW = $clog2(AW + 1);

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_MUL  = 2'd1;
    localparam logic [1:0] ENG_DIV  = 2'd2;

    // Sample window: 0 = s, 1..3 = x, y, z
    logic [W-1:0] old_reg [4];
    logic [W-1:0] mid_reg [4];
    logic [W-1:0] cur_reg [4];

    // Working registers
    logic [AW-1:0] h0_reg, h1_reg, hs_reg, d_reg;
    logic [AW-1:0] h0sq_reg, h1sq_reg, dif_reg, acc_reg, tmp_reg;

    // Engine
    logic [1:0]    eng_reg;
    logic [CW-1:0] cnt_reg;
    logic [3:0]    dst_reg;
    logic          second_reg;
    logic [AW-1:0] mc_reg, prod_reg;
    logic [BW-1:0] mb_reg;
    logic [AW:0]   rem_reg;
    logic [AW-1:0] num_reg, q_reg, dm_reg;
    logic          neg_reg;
    logic          done_reg;
    logic          sat_reg;
    logic [W-1:0]  res1_reg [3];
    logic [W-1:0]  res2_reg [3];

    // Output registers
    logic [W-1:0]  out1_reg [3];
    logic [W-1:0]  out2_reg [3];
    logic          degen_out_reg, sat_out_reg;

    logic [AW-1:0] a_val, b_val;
    logic [AW-1:0] f0_ext, f1_ext, f2_ext;
    logic [1:0]    fidx;
    logic [AW-1:0] old_s, mid_s, cur_s, h0_c, h1_c;

    logic          mul_last;
    logic [AW-1:0] mul_sum, mul_next;
    logic [AW:0]   rem_sh, rem_sub;
    logic          rem_ge;
    logic [AW-1:0] q_next, lim, mag, div_res;
    logic [AW-1:0] num_start, nm_start, dm_start;

    logic          wr_en;
    logic [3:0]    wr_dst;
    logic [AW-1:0] wr_data;

    // Sign extension of window samples and the spacings h0, h1
    assign fidx   = cmd.axis + 2'd1;
    assign f0_ext = {{(AW-W){old_reg[fidx][W-1]}}, old_reg[fidx]};
    assign f1_ext = {{(AW-W){mid_reg[fidx][W-1]}}, mid_reg[fidx]};
    assign f2_ext = {{(AW-W){cur_reg[fidx][W-1]}}, cur_reg[fidx]};
    assign old_s  = {{(AW-W){old_reg[0][W-1]}}, old_reg[0]};
    assign mid_s  = {{(AW-W){mid_reg[0][W-1]}}, mid_reg[0]};
    assign cur_s  = {{(AW-W){cur_reg[0][W-1]}}, cur_reg[0]};
    assign h0_c   = mid_s - old_s;
    assign h1_c   = cur_s - mid_s;

    assign status.degen = (h0_reg == '0) || (h1_reg == '0) || (hs_reg == '0);
    assign status.done  = done_reg;

    // Operand selects
    always_comb
    begin
        case (cmd.instr.a)
            tpld_pkg::SEL_H0:   a_val = h0_reg;
            tpld_pkg::SEL_H1:   a_val = h1_reg;
            tpld_pkg::SEL_HS:   a_val = hs_reg;
            tpld_pkg::SEL_D:    a_val = d_reg;
            tpld_pkg::SEL_H0SQ: a_val = h0sq_reg;
            tpld_pkg::SEL_H1SQ: a_val = h1sq_reg;
            tpld_pkg::SEL_DIF:  a_val = dif_reg;
            tpld_pkg::SEL_ACC:  a_val = acc_reg;
            tpld_pkg::SEL_TMP:  a_val = tmp_reg;
            tpld_pkg::SEL_F0:   a_val = f0_ext;
            tpld_pkg::SEL_F1:   a_val = f1_ext;
            tpld_pkg::SEL_F2:   a_val = f2_ext;
            default:            a_val = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.instr.b)
            tpld_pkg::SEL_H0:   b_val = h0_reg;
            tpld_pkg::SEL_H1:   b_val = h1_reg;
            tpld_pkg::SEL_HS:   b_val = hs_reg;
            tpld_pkg::SEL_D:    b_val = d_reg;
            tpld_pkg::SEL_H0SQ: b_val = h0sq_reg;
            tpld_pkg::SEL_H1SQ: b_val = h1sq_reg;
            tpld_pkg::SEL_DIF:  b_val = dif_reg;
            tpld_pkg::SEL_ACC:  b_val = acc_reg;
            tpld_pkg::SEL_TMP:  b_val = tmp_reg;
            tpld_pkg::SEL_F0:   b_val = f0_ext;
            tpld_pkg::SEL_F1:   b_val = f1_ext;
            tpld_pkg::SEL_F2:   b_val = f2_ext;
            default:            b_val = '0;
        endcase
    end

    // Shift-add multiply step; top multiplier bit carries negative weight
    assign mul_last = (cnt_reg == CW'(1));
    assign mul_sum  = mul_last ? (prod_reg - mc_reg) : (prod_reg + mc_reg);
    assign mul_next = mb_reg[0] ? mul_sum : prod_reg;

    // Restoring divide step
    assign rem_sh  = {rem_reg[AW-1:0], num_reg[AW-1]};
    assign rem_sub = rem_sh - {1'b0, dm_reg};
    assign rem_ge  = (rem_sh >= {1'b0, dm_reg});
    assign q_next  = {q_reg[AW-2:0], rem_ge};

    // Clip magnitude to the signed output range, then apply the sign
    assign lim     = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}} + {{(AW-1){1'b0}}, neg_reg};
    assign mag     = (q_next > lim) ? lim : q_next;
    assign div_res = neg_reg ? (AW'(0) - mag) : mag;

    // Divider start values
    assign num_start = (cmd.instr.op == tpld_pkg::OP_DIV1) ? (acc_reg << FRAC_BITS)
                                                            : (acc_reg << (2 * FRAC_BITS + 1));
    assign nm_start  = num_start[AW-1] ? (AW'(0) - num_start) : num_start;
    assign dm_start  = d_reg[AW-1] ? (AW'(0) - d_reg) : d_reg;

    // Working register write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_dst  = cmd.instr.dst;
        wr_data = a_val + b_val;
        if (cmd.start && (cmd.instr.op == tpld_pkg::OP_ADD))
        begin
            wr_en = 1'b1;
        end
        else if (cmd.start && (cmd.instr.op == tpld_pkg::OP_SUB))
        begin
            wr_en   = 1'b1;
            wr_data = a_val - b_val;
        end
        else if ((eng_reg == ENG_MUL) && mul_last)
        begin
            wr_en   = 1'b1;
            wr_dst  = dst_reg;
            wr_data = mul_next;
        end
    end

    // Window and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg[0] <= s_val;
            cur_reg[1] <= x_val;
            cur_reg[2] <= y_val;
            cur_reg[3] <= z_val;
        end
        if (cmd.shift || cmd.commit)
        begin
            old_reg <= mid_reg;
            mid_reg <= cur_reg;
        end
        if (cmd.calc_h)
        begin
            h0_reg <= h0_c;
            h1_reg <= h1_c;
            hs_reg <= h0_c + h1_c;
        end
        if (wr_en)
        begin
            case (wr_dst)
                tpld_pkg::SEL_D:    d_reg    <= wr_data;
                tpld_pkg::SEL_H0SQ: h0sq_reg <= wr_data;
                tpld_pkg::SEL_H1SQ: h1sq_reg <= wr_data;
                tpld_pkg::SEL_DIF:  dif_reg  <= wr_data;
                tpld_pkg::SEL_ACC:  acc_reg  <= wr_data;
                tpld_pkg::SEL_TMP:  tmp_reg  <= wr_data;
                default:            tmp_reg  <= tmp_reg;
            endcase
        end
    end

    // Multiply / divide engine payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dst_reg    <= cmd.instr.dst;
            second_reg <= (cmd.instr.op == tpld_pkg::OP_DIV2);
            mc_reg     <= a_val;
            mb_reg     <= b_val[BW-1:0];
            prod_reg   <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            num_reg    <= nm_start;
            dm_reg     <= dm_start;
            neg_reg    <= num_start[AW-1] ^ d_reg[AW-1];
        end
        else if (eng_reg == ENG_MUL)
        begin
            prod_reg <= mul_next;
            mc_reg   <= mc_reg << 1;
            mb_reg   <= mb_reg >> 1;
        end
        else if (eng_reg == ENG_DIV)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_sh;
            q_reg   <= q_next;
            num_reg <= num_reg << 1;
            if (cnt_reg == CW'(1))
            begin
                if (second_reg)
                    res2_reg[cmd.axis] <= div_res[W-1:0];
                else
                    res1_reg[cmd.axis] <= div_res[W-1:0];
            end
        end
    end

    // Engine control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg  <= ENG_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.clr_sat)
                sat_reg <= 1'b0;
            if (cmd.start)
            begin
                case (cmd.instr.op)
                    tpld_pkg::OP_MUL:
                    begin
                        eng_reg <= ENG_MUL;
                        cnt_reg <= CW'(BW);
                    end
                    tpld_pkg::OP_DIV1, tpld_pkg::OP_DIV2:
                    begin
                        eng_reg <= ENG_DIV;
                        cnt_reg <= CW'(AW);
                    end
                    default:
                    begin
                        done_reg <= 1'b1;
                    end
                endcase
            end
            else if (eng_reg != ENG_IDLE)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    eng_reg  <= ENG_IDLE;
                    done_reg <= 1'b1;
                    if ((eng_reg == ENG_DIV) && (q_next > lim))
                        sat_reg <= 1'b1;
                end
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            degen_out_reg <= cmd.degen;
            sat_out_reg   <= cmd.degen ? 1'b0 : sat_reg;
            for (int k = 0; k < 3; k++)
            begin
                out1_reg[k] <= cmd.degen ? '0 : res1_reg[k];
                out2_reg[k] <= cmd.degen ? '0 : res2_reg[k];
            end
        end
    end

    assign dx_ds      = out1_reg[0];
    assign dy_ds      = out1_reg[1];
    assign dz_ds      = out1_reg[2];
    assign d2x_ds2    = out2_reg[0];
    assign d2y_ds2    = out2_reg[1];
    assign d2z_ds2    = out2_reg[2];
    assign degenerate = degen_out_reg;
    assign saturated  = sat_out_reg;

endmodule

`default_nettype wire

// File: rtl/three_point_lagrange_derivative.sv
// Top level of the three-point Lagrange derivative block: controller and
// datapath. Depends on tpld_pkg, tpld_ctrl and tpld_datapath.
//
// Usage: samples (s_val, x_val, y_val, z_val, signed fixed point) enter on the
// sample_valid / sample_ready channel. The block keeps a window of the last
// three samples; the first two after reset only fill the window and give no
// item. Every later sample gives one item on result_valid / result_ready:
// first and second derivatives of x, y, z at the middle sample, clipped to
// range (saturated set), or all zero with degenerate set when two s values
// in the window are equal.
// Samples are taken one at a time; a window-filling sample only shifts the
// window. The run time of a producing sample is set by the bit-serial
// multiplier (22 products) and the restoring divider (6 quotients), both
// of which a degenerate sample skips.
// The result sits in an output register, so the next sample is taken while
// the receiver stalls; a further result waits until that register is freed.
// Reset empties the window and drops any pending result.
`default_nettype none

module three_point_lagrange_derivative #(
    parameter int DATA_WIDTH = tpld_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = tpld_pkg::FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire logic [DATA_WIDTH-1:0] s_val,
    input  wire logic [DATA_WIDTH-1:0] x_val,
    input  wire logic [DATA_WIDTH-1:0] y_val,
    input  wire logic [DATA_WIDTH-1:0] z_val,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic [DATA_WIDTH-1:0]      dx_ds,
    output logic [DATA_WIDTH-1:0]      dy_ds,
    output logic [DATA_WIDTH-1:0]      dz_ds,
    output logic [DATA_WIDTH-1:0]      d2x_ds2,
    output logic [DATA_WIDTH-1:0]      d2y_ds2,
    output logic [DATA_WIDTH-1:0]      d2z_ds2,
    output logic                       degenerate,
    output logic                       saturated
);

    tpld_pkg::cmd_t    cmd;
    tpld_pkg::status_t status;

    tpld_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    tpld_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_val      (s_val),
        .x_val      (x_val),
        .y_val      (y_val),
        .z_val      (z_val),
        .cmd        (cmd),
        .status     (status),
        .dx_ds      (dx_ds),
        .dy_ds      (dy_ds),
        .dz_ds      (dz_ds),
        .d2x_ds2    (d2x_ds2),
        .d2y_ds2    (d2y_ds2),
        .d2z_ds2    (d2z_ds2),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

endmodule

`default_nettype wire
